@@ rtl/assert_macros.svh @@
// assertion macros for the top level of the bc1 color index encoder
// depends on nothing; clock and reset names aclk / aresetn are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define BC1CI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition implies another on the same edge
`define BC1CI_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

`endif

@@ rtl/bc1ci_pkg.sv @@
// shared types and constants of the bc1 color index encoder
// used by the palette builder, the pixel lanes and the top level
`default_nettype none

package bc1ci_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned NUM_ROWS  = 4;

    localparam logic [7:0]  MASK_5BIT = 8'hF8;
    localparam logic [7:0]  MASK_6BIT = 8'hFC;
    // reciprocal of three in 16-bit fixed point, exact for sums up to 765
    localparam logic [14:0] THIRD_MUL = 15'((1 << 16) / 3 + 1);

    // channel0 sits in the low byte
    typedef struct packed {
        logic [7:0] ch2;
        logic [7:0] ch1;
        logic [7:0] ch0;
    } rgb_t;

    // entry 0 = max, 1 = min, 2 = (2max+min)/3, 3 = (max+2min)/3
    typedef struct packed {
        rgb_t c3;
        rgb_t c2;
        rgb_t c1;
        rgb_t c0;
    } palette_t;

    typedef logic [1:0] pix_idx_t;
    typedef logic [1:0] row_cnt_t;

    localparam row_cnt_t LAST_ROW = 2'd3;

endpackage

`default_nettype wire

@@ rtl/bc1ci_palette.sv @@
// builds the four-entry 5:6:5 palette from the two endpoint colors
// depends on bc1ci_pkg
`default_nettype none

module bc1ci_palette
    import bc1ci_pkg::*;
(
    input  wire rgb_t     endpoint_max,
    input  wire rgb_t     endpoint_min,
    output palette_t      palette
);

    function automatic rgb_t expand565(input rgb_t c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        rgb_t       o;
        r = c.ch0 & MASK_5BIT;
        g = c.ch1 & MASK_6BIT;
        b = c.ch2 & MASK_5BIT;
        o.ch0 = r | (r >> 5);
        o.ch1 = g | (g >> 6);
        o.ch2 = b | (b >> 5);
        return o;
    endfunction

    // floor(x/3) for x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(THIRD_MUL);
        return prod[23:16];
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b);
        return div3({1'b0, a, 1'b0} + {2'b00, b});
    endfunction

    rgb_t c0;
    rgb_t c1;

    always_comb begin
        c0 = expand565(endpoint_max);
        c1 = expand565(endpoint_min);
        palette.c0     = c0;
        palette.c1     = c1;
        palette.c2.ch0 = mix(c0.ch0, c1.ch0);
        palette.c2.ch1 = mix(c0.ch1, c1.ch1);
        palette.c2.ch2 = mix(c0.ch2, c1.ch2);
        palette.c3.ch0 = mix(c1.ch0, c0.ch0);
        palette.c3.ch1 = mix(c1.ch1, c0.ch1);
        palette.c3.ch2 = mix(c1.ch2, c0.ch2);
    end

endmodule

`default_nettype wire

@@ rtl/bc1ci_lane.sv @@
// one pixel lane: distances to the four palette entries and index choice
// depends on bc1ci_pkg
`default_nettype none

module bc1ci_lane
    import bc1ci_pkg::*;
(
    input  wire palette_t palette,
    input  wire rgb_t     pixel,
    output pix_idx_t      index
);

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [9:0] abs_dist(input rgb_t p, input rgb_t q);
        return {2'b00, absdiff(p.ch0, q.ch0)} + {2'b00, absdiff(p.ch1, q.ch1)}
             + {2'b00, absdiff(p.ch2, q.ch2)};
    endfunction

    logic [9:0] d0, d1, d2, d3;
    logic       b0, b1, b2, b3, b4;

    always_comb begin
        d0 = abs_dist(palette.c0, pixel);
        d1 = abs_dist(palette.c1, pixel);
        d2 = abs_dist(palette.c2, pixel);
        d3 = abs_dist(palette.c3, pixel);
        b0 = d0 > d3;
        b1 = d1 > d2;
        b2 = d0 > d2;
        b3 = d1 > d3;
        b4 = d2 > d3;
        index = {(b2 & b1) | (b3 & b0), b4 & b0};
    end

endmodule

`default_nettype wire

@@ rtl/bc1_color_index_encoder_unit.sv @@
// bc1 color index encoder: usage
// s_ channel takes one texel row per word: the block's two endpoints and four
// pixels. m_ channel gives one 32-bit index word per four rows, pixel p
// (p = 4*row + column) at bits 2p+1:2p, first row in the low byte.
// pipeline: palette build and pixel registers, four distance lanes, then the
// row gather with the output register.
// the fourth row of a block passes the pixel registers and the row index
// register before its word is loaded into the output register for m_tvalid.
// throughput: one row per cycle unless stalled; one word per four rows.
// reset (aresetn low, synchronous) empties the pipeline, clears the row
// counter and the gathered indices; the next row accepted is row zero.
// when the receiver stalls, the finished word holds in the output register
// while up to three more rows gather and two sit in the pipe; s_tready drops
// only when a fourth row would need the still-occupied output register.
// depends on bc1ci_pkg, bc1ci_palette, bc1ci_lane, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bc1_color_index_encoder_unit
    import bc1ci_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // endpoint_max[23:0], endpoint_min[47:24], pixel_a[71:48],
    // pixel_b[95:72], pixel_c[119:96], pixel_d[143:120]
    input  wire [143:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // index_word[31:0]
    output logic [31:0] m_tdata
);

    palette_t pal_comb;
    rgb_t     pix_in [NUM_LANES];

    // stage 0: palette and pixels
    logic     p0_valid_reg, p0_valid_next;
    palette_t pal_reg;
    rgb_t     pix_reg [NUM_LANES];

    // stage 1: lane indices of one row
    logic     p1_valid_reg, p1_valid_next;
    logic [7:0] row_idx_reg;
    logic [7:0] row_idx_comb;

    // gather and output
    row_cnt_t   row_cnt_reg, row_cnt_next;
    logic [23:0] partial_reg, partial_next;
    logic       m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic out_free, p1_go, p1_free, p0_free, p0_go;

    bc1ci_palette u_palette (
        .endpoint_max (rgb_t'(s_tdata[23:0])),
        .endpoint_min (rgb_t'(s_tdata[47:24])),
        .palette      (pal_comb)
    );

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            pix_in[i] = rgb_t'(s_tdata[48 + 24*i +: 24]);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bc1ci_lane u_lane (
            .palette (pal_reg),
            .pixel   (pix_reg[g]),
            .index   (row_idx_comb[2*g +: 2])
        );
    end

    // back-pressure: only the last row of a block needs the output register
    always_comb begin
        out_free = !m_valid_reg || m_tready;
        p1_go    = p1_valid_reg && ((row_cnt_reg != LAST_ROW) || out_free);
        p1_free  = !p1_valid_reg || p1_go;
        p0_go    = p0_valid_reg && p1_free;
        p0_free  = !p0_valid_reg || p1_free;
        s_tready = p0_free;
    end

    always_comb begin
        p0_valid_next = p0_free ? s_tvalid : p0_valid_reg;
        p1_valid_next = p1_free ? p0_valid_reg : p1_valid_reg;
        row_cnt_next  = row_cnt_reg;
        partial_next  = partial_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        if (p1_go) begin
            if (row_cnt_reg == LAST_ROW) begin
                m_data_next  = {row_idx_reg, partial_reg};
                m_valid_next = 1'b1;
                row_cnt_next = '0;
                partial_next = '0;
            end else begin
                unique case (row_cnt_reg)
                    2'd0:    partial_next[7:0]   = row_idx_reg;
                    2'd1:    partial_next[15:8]  = row_idx_reg;
                    default: partial_next[23:16] = row_idx_reg;
                endcase
                row_cnt_next = row_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            row_cnt_reg  <= '0;
            partial_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            p0_valid_reg <= p0_valid_next;
            p1_valid_reg <= p1_valid_next;
            row_cnt_reg  <= row_cnt_next;
            partial_reg  <= partial_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && p0_free) begin
            pal_reg <= pal_comb;
            for (int i = 0; i < NUM_LANES; i++) begin
                pix_reg[i] <= pix_in[i];
            end
        end
        if (p0_go) begin
            row_idx_reg <= row_idx_comb;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `BC1CI_ASSERT(a_word_after_last_row,
        $rose(m_valid_reg) |-> ($past(row_cnt_reg) == LAST_ROW && row_cnt_reg == 2'd0),
        "index word raised without a fourth row")
    `BC1CI_ASSERT_IMPL(a_fresh_block_clear, row_cnt_reg == 2'd0, partial_reg == 24'd0,
        "gathered indices not cleared at block start")
    `BC1CI_ASSERT_IMPL(a_stall_only_when_full, !s_tready,
        p0_valid_reg && p1_valid_reg && m_valid_reg && row_cnt_reg == LAST_ROW,
        "input stalled with room in the pipeline")
    `BC1CI_ASSERT(a_stage1_holds,
        (p1_valid_reg && !p1_go) |=> (p1_valid_reg && $stable(row_idx_reg)),
        "stalled row indices lost")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench of bc1_color_index_encoder_unit: texel rows in on s_,
// index words out on m_, checked against an in-bench palette and index predictor
// depends on bc1ci_pkg and the rtl of the encoder unit
module tb;
    import bc1ci_pkg::*;

    localparam int RANDOM_BLOCKS = 163;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [143:0] data;
        bit           typed;
        logic [31:0]  word;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // endpoint_max[23:0], endpoint_min[47:24], pixel_a[71:48],
    // pixel_b[95:72], pixel_c[119:96], pixel_d[143:120]
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // index_word[31:0]
    logic [31:0]  m_tdata;

    // predictor state: rows of the current block and their index bytes
    row_cnt_t     rows_taken = '0;
    logic [23:0]  gathered_codes = '0;
    logic [31:0]  pending_words[$];

    stim_row_t    directed_rows[$];
    int           rows_sent = 0;
    int           words_checked = 0;
    int           errors = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;
    bit           holding = 1'b0;

    bc1_color_index_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [143:0] pack_row(input rgb_t mx, input rgb_t mn, input rgb_t pa,
                                              input rgb_t pb, input rgb_t pc, input rgb_t pd);
        return {pd, pc, pb, pa, mn, mx};
    endfunction

    // quantize to 5:6:5 and widen back by bit replication
    function automatic rgb_t widen565(input rgb_t c);
        rgb_t w;
        w.ch0 = (c.ch0 & MASK_5BIT) | ((c.ch0 & MASK_5BIT) >> 5);
        w.ch1 = (c.ch1 & MASK_6BIT) | ((c.ch1 & MASK_6BIT) >> 6);
        w.ch2 = (c.ch2 & MASK_5BIT) | ((c.ch2 & MASK_5BIT) >> 5);
        return w;
    endfunction

    // floor((2a + b) / 3) per channel
    function automatic rgb_t third_mix(input rgb_t a, input rgb_t b);
        rgb_t m;
        m.ch0 = 8'((2 * a.ch0 + b.ch0) / 3);
        m.ch1 = 8'((2 * a.ch1 + b.ch1) / 3);
        m.ch2 = 8'((2 * a.ch2 + b.ch2) / 3);
        return m;
    endfunction

    function automatic logic [9:0] abs_sum(input rgb_t a, input rgb_t b);
        logic [9:0] s;
        s = 10'((a.ch0 > b.ch0) ? a.ch0 - b.ch0 : b.ch0 - a.ch0);
        s += 10'((a.ch1 > b.ch1) ? a.ch1 - b.ch1 : b.ch1 - a.ch1);
        s += 10'((a.ch2 > b.ch2) ? a.ch2 - b.ch2 : b.ch2 - a.ch2);
        return s;
    endfunction

    // index byte of one row, pixel a in bits 1:0
    function automatic logic [7:0] row_code(input logic [143:0] d);
        palette_t   pal;
        rgb_t       px;
        logic [9:0] span [4];
        logic       b0, b1, b2, b3, b4;
        logic [7:0] code;
        code = '0;
        pal.c0 = widen565(d[23:0]);
        pal.c1 = widen565(d[47:24]);
        pal.c2 = third_mix(pal.c0, pal.c1);
        pal.c3 = third_mix(pal.c1, pal.c0);
        for (int p = 0; p < NUM_LANES; p++) begin
            px = d[48 + 24 * p +: 24];
            for (int k = 0; k < 4; k++) span[k] = abs_sum(pal[24 * k +: 24], px);
            b0 = span[0] > span[3];
            b1 = span[1] > span[2];
            b2 = span[0] > span[2];
            b3 = span[1] > span[3];
            b4 = span[2] > span[3];
            code[2 * p +: 2] = {(b2 & b1) | (b3 & b0), b4 & b0};
        end
        return code;
    endfunction

    function automatic rgb_t random_endpoint();
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic rgb_t random_pixel(input rgb_t hi, input rgb_t lo);
        rgb_t px;
        int   v, w;
        case ($urandom_range(3))
            0: px = 24'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: px = hi;
                    1: px = lo;
                    2: px = 24'h000000;
                    default: px = 24'hFFFFFF;
                endcase
            end
            default: begin
                // near a palette entry, so that ties and close calls show up
                w = $urandom_range(3);
                for (int k = 0; k < 3; k++) begin
                    v = (int'(hi[8 * k +: 8]) * (3 - w) + int'(lo[8 * k +: 8]) * w) / 3
                        + int'($urandom_range(8)) - 4;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    px[8 * k +: 8] = v[7:0];
                end
            end
        endcase
        return px;
    endfunction

    task automatic note_row(input logic [143:0] d, input bit typed, input logic [31:0] word);
        logic [7:0] code;
        code = row_code(d);
        if (rows_taken == LAST_ROW) begin
            pending_words.push_back(typed ? word : {code, gathered_codes});
            gathered_codes = '0;
            rows_taken = '0;
        end else begin
            gathered_codes[8 * rows_taken +: 8] = code;
            rows_taken = rows_taken + 1'b1;
        end
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_row(input logic [143:0] d, input bit typed, input logic [31:0] word);
        int  gap;
        bit  taken;
        gap = (!calm && !holding && $urandom_range(99) < 8) ? $urandom_range(1, 2) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do begin
            @(negedge aclk);
            taken = s_tvalid && s_tready;
            @(posedge aclk);
        end while (!taken);
        note_row(d, typed, word);
        rows_sent++;
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holding  = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // outputs are stable from the falling edge to the accepting rising edge
    always @(negedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("index_word: unexpected word, actual %h", m_tdata);
                errors++;
            end else begin
                if (m_tdata !== pending_words[0]) begin
                    $error("index_word: expected %h, actual %h", pending_words[0], m_tdata);
                    errors++;
                end
                void'(pending_words.pop_front());
            end
            words_checked++;
        end
    end

    initial begin
        #1000000;
        $display("tb failed");
        $finish;
    end

    initial begin
        rgb_t mx, mn;
        bit   vary;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        // all zero: every distance ties, index 0 everywhere
        repeat (3) directed_rows.push_back('{pack_row(0, 0, 0, 0, 0, 0), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(0, 0, 0, 0, 0, 0), 1'b1, 32'h0000_0000});
        // white/black endpoints, pixels on entries 0, 1, 2, 3
        repeat (3) directed_rows.push_back('{pack_row(24'hFFFFFF, 0, 24'hFFFFFF, 0,
                                             24'hAAAAAA, 24'h555555), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'hFFFFFF, 0, 24'hFFFFFF, 0,
                                  24'hAAAAAA, 24'h555555), 1'b1, 32'hE4E4_E4E4});
        // all ones in every field
        repeat (3) directed_rows.push_back('{{6{24'hFFFFFF}}, 1'b0, 32'h0});
        directed_rows.push_back('{{6{24'hFFFFFF}}, 1'b1, 32'h0000_0000});
        // endpoints change from row to row, one row with swapped, one with equal
        directed_rows.push_back('{pack_row(0, 24'hFFFFFF, 24'hFFFFFF, 0,
                                  24'hAAAAAA, 24'h555555), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'h123456, 24'h654321, 24'hFF0000, 24'h00FF00,
                                  24'h0000FF, 24'h808080), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'hF80000, 24'h07FC00, 24'hF80000, 24'h07FC00,
                                  24'h7F7E00, 24'h3C3C3C), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'h800080, 24'h800080, 24'h800080, 24'h7F0081,
                                  0, 24'hFFFFFF), 1'b0, 32'h0});
        // endpoint bits below the 5:6:5 grid are dropped
        directed_rows.push_back('{pack_row(24'h070307, 0, 24'h070307, 0,
                                  24'h7F7F7F, 24'hFFFFFF), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'hFFFFFF, 24'h070307, 24'h0F070F, 24'h080408,
                                  24'hF8FCF8, 24'h010101), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'hF8FCF8, 24'h080408, 24'hA5A6A5, 24'h5A595A,
                                  24'h555555, 24'hAAAAAA), 1'b0, 32'h0});
        directed_rows.push_back('{pack_row(24'h0000FF, 24'hFF0000, 24'h0000FF, 24'hFF0000,
                                  24'h550055, 24'hAA00AA), 1'b0, 32'h0});

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].word);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            calm = (blk >= 60 && blk < 90);
            if (blk == 120) hold_req = 1'b1;
            vary = ($urandom_range(9) == 0);
            mx = random_endpoint();
            mn = ($urandom_range(9) == 0) ? mx : random_endpoint();
            for (int r = 0; r < NUM_ROWS; r++) begin
                if (vary && r > 0) begin
                    mx = random_endpoint();
                    mn = random_endpoint();
                end
                send_row(pack_row(mx, mn, random_pixel(mx, mn), random_pixel(mx, mn),
                                  random_pixel(mx, mn), random_pixel(mx, mn)), 1'b0, 32'h0);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d texel rows sent (directed extremes, varying endpoints, random blocks)",
                 rows_sent);
        $display("%0d index words checked, %0d mismatches", words_checked, errors);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
